// ===== hdl/tlca_pkg.sv =====
// ---------------------------------------------------------------------------
// tlca_pkg: shared types, codes and control store for the LCA engine
// Holds the node and depth types, the micro-operation and jump condition
// codes, the step addresses and the read-only microprogram itself.
// ---------------------------------------------------------------------------
package tlca_pkg;

   localparam int ID_W    = 10;
   localparam int DEPTH_W = 10;
   localparam int ID_SPAN = 1024;

   typedef logic [ID_W-1:0]    node_type;
   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [3:0]         op_type;
   typedef logic [2:0]         cond_type;
   typedef logic [3:0]         step_type;

   // Micro-operations carried out by the datapath.
   localparam op_type OP_NOP           = 4'd0;
   localparam op_type OP_DEP_RD_PARENT = 4'd1;
   localparam op_type OP_INS_HEAD      = 4'd2;
   localparam op_type OP_ANC_RD_MID    = 4'd3;
   localparam op_type OP_INS_FILL      = 4'd4;
   localparam op_type OP_DEP_RD_XY     = 4'd5;
   localparam op_type OP_Q_ORDER       = 4'd6;
   localparam op_type OP_ANC_RD_X      = 4'd7;
   localparam op_type OP_L1_PICK       = 4'd8;
   localparam op_type OP_L1_STEP       = 4'd9;
   localparam op_type OP_LVL_TOP       = 4'd10;
   localparam op_type OP_ANC_RD_XY     = 4'd11;
   localparam op_type OP_L2_STEP       = 4'd12;
   localparam op_type OP_OUT_ANC       = 4'd13;
   localparam op_type OP_OUT_X         = 4'd14;

   // Jump conditions.
   localparam cond_type C_NEVER    = 3'd0;
   localparam cond_type C_ALWAYS   = 3'd1;
   localparam cond_type C_START    = 3'd2;
   localparam cond_type C_SLOT0    = 3'd3;
   localparam cond_type C_LVL_MORE = 3'd4;
   localparam cond_type C_LVL_NZ   = 3'd5;
   localparam cond_type C_EQ       = 3'd6;

   // Step addresses of the microprogram.
   localparam step_type ST_IDLE  = 4'd0;
   localparam step_type ST_I0    = 4'd1;
   localparam step_type ST_I1    = 4'd2;
   localparam step_type ST_I2    = 4'd3;
   localparam step_type ST_I3    = 4'd4;
   localparam step_type ST_Q0    = 4'd5;
   localparam step_type ST_Q1    = 4'd6;
   localparam step_type ST_Q2    = 4'd7;
   localparam step_type ST_Q3    = 4'd8;
   localparam step_type ST_Q4    = 4'd9;
   localparam step_type ST_Q5    = 4'd10;
   localparam step_type ST_Q6    = 4'd11;
   localparam step_type ST_Q7    = 4'd12;
   localparam step_type ST_Q8    = 4'd13;
   localparam step_type ST_Q9    = 4'd14;
   localparam step_type ST_QOUTX = 4'd15;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     fall_idle;
   } ctl_word_type;

   typedef struct packed {
      logic slot0;
      logic lvl_more;
      logic lvl_nz;
      logic xy_eq;
   } dp_status_type;

   typedef struct packed {
      logic     valid;
      node_type node;
   } dp_result_type;

   function automatic ctl_word_type cw(input op_type op, input cond_type cond,
                                       input step_type target, input logic fall_idle);
      ctl_word_type w;
      w.op        = op;
      w.cond      = cond;
      w.target    = target;
      w.fall_idle = fall_idle;
      return w;
   endfunction

   // The control store. A taken jump goes to the target; otherwise the
   // sequencer steps on, or back to idle when fall_idle is set.
   function automatic ctl_word_type uc_rom(input step_type step);
      ctl_word_type w;
      case (step)
         ST_IDLE:  w = cw(OP_NOP,           C_START,    ST_Q0,    1'b0);
         ST_I0:    w = cw(OP_DEP_RD_PARENT, C_SLOT0,    ST_IDLE,  1'b0);
         ST_I1:    w = cw(OP_INS_HEAD,      C_NEVER,    ST_IDLE,  1'b0);
         ST_I2:    w = cw(OP_ANC_RD_MID,    C_NEVER,    ST_IDLE,  1'b0);
         ST_I3:    w = cw(OP_INS_FILL,      C_LVL_MORE, ST_I2,    1'b1);
         ST_Q0:    w = cw(OP_DEP_RD_XY,     C_NEVER,    ST_IDLE,  1'b0);
         ST_Q1:    w = cw(OP_Q_ORDER,       C_NEVER,    ST_IDLE,  1'b0);
         ST_Q2:    w = cw(OP_ANC_RD_X,      C_NEVER,    ST_IDLE,  1'b0);
         ST_Q3:    w = cw(OP_L1_PICK,       C_NEVER,    ST_IDLE,  1'b0);
         ST_Q4:    w = cw(OP_L1_STEP,       C_LVL_NZ,   ST_Q3,    1'b0);
         ST_Q5:    w = cw(OP_LVL_TOP,       C_EQ,       ST_QOUTX, 1'b0);
         ST_Q6:    w = cw(OP_ANC_RD_XY,     C_NEVER,    ST_IDLE,  1'b0);
         ST_Q7:    w = cw(OP_L2_STEP,       C_LVL_NZ,   ST_Q6,    1'b0);
         ST_Q8:    w = cw(OP_ANC_RD_X,      C_NEVER,    ST_IDLE,  1'b0);
         ST_Q9:    w = cw(OP_OUT_ANC,       C_ALWAYS,   ST_IDLE,  1'b0);
         ST_QOUTX: w = cw(OP_OUT_X,         C_ALWAYS,   ST_IDLE,  1'b0);
         default:  w = cw(OP_NOP,           C_ALWAYS,   ST_IDLE,  1'b0);
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/tree_lca_binary_lifting_core.sv =====
// ---------------------------------------------------------------------------
// tree_lca_binary_lifting_core: lowest common ancestor engine
// Binary lifting over a rooted tree built by parent-before-child inserts,
// run by a microcoded sequencer over a two-table datapath.
// ---------------------------------------------------------------------------
// Usage. A request word (req_type, req_node_a, req_node_b) is taken at a
// rising edge where start is high and busy is low. req_type low inserts
// req_node_a under parent req_node_b (zero makes it a root); req_type high
// asks for the lowest common ancestor of the two nodes. Inserts give no
// result word. A query gives one result word on rsp_ancestor_node, shown for
// exactly one cycle with rsp_strobe high; the receiver cannot stall it.
// Busy stays high while an insert or query routine runs; an insert of
// node 0 ends at its first step. A query runs both lifting loops, and
// skips the second when lifting to equal depth already meets the other
// node; the result word appears the cycle after busy falls, and a new
// request may be taken in that same cycle. Both query loops pair a
// registered ancestor table read step with an update step per level.
// Reset returns the sequencer to idle and drops rsp_strobe. The tables are
// not cleared: node 0 reads as zero by design and every other entry is
// meaningful only once its node has been inserted.
// ---------------------------------------------------------------------------
module tree_lca_binary_lifting_core #(
   parameter int NODE_COUNT  = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_type,
   input  logic [tlca_pkg::ID_W-1:0] req_node_a,
   input  logic [tlca_pkg::ID_W-1:0] req_node_b,
   output logic                      rsp_strobe,
   output logic [tlca_pkg::ID_W-1:0] rsp_ancestor_node
);

   tlca_pkg::ctl_word_type  ctl;
   tlca_pkg::dp_status_type status;
   tlca_pkg::dp_result_type result;

   tlca_pkg::node_type req_a_ff, req_a_in;
   tlca_pkg::node_type req_b_ff, req_b_in;
   logic               rsp_strobe_ff;
   tlca_pkg::node_type rsp_node_ff, rsp_node_in;
   logic               accept;

   // A request word is taken only while the sequencer sits idle.
   assign accept = start && !busy;

   // The node ids are held for the whole routine; the sequencer reads the
   // request kind straight from the port in its idle step.
   always_comb begin
      req_a_in    = accept ? req_node_a : req_a_ff;
      req_b_in    = accept ? req_node_b : req_b_ff;
      rsp_node_in = result.valid ? result.node : rsp_node_ff;
   end

   always_ff @(posedge clock) begin
      req_a_ff    <= req_a_in;
      req_b_ff    <= req_b_in;
      rsp_node_ff <= rsp_node_in;
   end

   // The result word is registered, so it leaves in the cycle after the step
   // that produced it, by which time the sequencer is back in idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= result.valid;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_ancestor_node = rsp_node_ff;

   tlca_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .ctl      (ctl),
      .busy     (busy)
   );

   tlca_dpath #(
      .NODE_COUNT  (NODE_COUNT),
      .LIFT_LEVELS (LIFT_LEVELS)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .req_a  (req_a_ff),
      .req_b  (req_b_ff),
      .status (status),
      .result (result)
   );

   // Every routine is at least one step long, so a taken word raises busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request taken but the sequencer stayed idle");

   // A result word only ever closes a routine that was running.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without a running query");

   // One query gives one word, so the strobe is never held high.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

endmodule

// ===== hdl/tlca_useq.sv =====
// ---------------------------------------------------------------------------
// tlca_useq: microprogram sequencer
// Step counter over the control store, with conditional jumps on datapath
// status and a dispatch from idle on the request kind.
// ---------------------------------------------------------------------------
module tlca_useq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_type,
   input  tlca_pkg::dp_status_type status,
   output tlca_pkg::ctl_word_type  ctl,
   output logic                    busy
);

   tlca_pkg::step_type step_ff;
   tlca_pkg::step_type step_in;
   logic               taken;

   assign ctl  = tlca_pkg::uc_rom(step_ff);
   assign busy = (step_ff != tlca_pkg::ST_IDLE);

   always_comb begin
      case (ctl.cond)
         tlca_pkg::C_NEVER:    taken = 1'b0;
         tlca_pkg::C_ALWAYS:   taken = 1'b1;
         tlca_pkg::C_SLOT0:    taken = status.slot0;
         tlca_pkg::C_LVL_MORE: taken = status.lvl_more;
         tlca_pkg::C_LVL_NZ:   taken = status.lvl_nz;
         tlca_pkg::C_EQ:       taken = status.xy_eq;
         default:              taken = 1'b0;
      endcase

      if (ctl.cond == tlca_pkg::C_START) begin
         // Queries branch to their own routine; inserts start on the next step.
         if (!start) begin
            step_in = step_ff;
         end else if (req_type) begin
            step_in = ctl.target;
         end else begin
            step_in = step_ff + tlca_pkg::step_type'(1);
         end
      end else if (taken) begin
         step_in = ctl.target;
      end else if (ctl.fall_idle) begin
         step_in = tlca_pkg::ST_IDLE;
      end else begin
         step_in = step_ff + tlca_pkg::step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= tlca_pkg::ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (step_ff == tlca_pkg::ST_IDLE && !start) |=> (step_ff == tlca_pkg::ST_IDLE))
      else $error("sequencer left idle without a request");

endmodule

// ===== hdl/tlca_dpath.sv =====
// ---------------------------------------------------------------------------
// tlca_dpath: lifting datapath and tables
// Depth table and ancestor table, each with two registered read ports and
// one write port, plus the working registers driven by the micro-operations.
// ---------------------------------------------------------------------------
module tlca_dpath #(
   parameter int NODE_COUNT  = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tlca_pkg::ctl_word_type  ctl,
   input  tlca_pkg::node_type      req_a,
   input  tlca_pkg::node_type      req_b,
   output tlca_pkg::dp_status_type status,
   output tlca_pkg::dp_result_type result
);

   // Ids are ten bits wide, so no more than ID_SPAN slots are ever addressed.
   localparam int SLOT_COUNT = (NODE_COUNT < tlca_pkg::ID_SPAN) ? NODE_COUNT
                                                               : tlca_pkg::ID_SPAN;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int ANC_DEPTH  = SLOT_COUNT * LIFT_LEVELS;
   localparam int ANC_AW     = $clog2(ANC_DEPTH);
   localparam int LVL_W      = $clog2(LIFT_LEVELS);
   localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LIFT_LEVELS - 1);

   // Id modulo slot count by conditional subtraction of shifted multiples.
   function automatic logic [SLOT_W-1:0] slot_of(input tlca_pkg::node_type v);
      tlca_pkg::node_type r;
      int                 lim;
      r = v;
      for (int k = tlca_pkg::ID_W - 1; k >= 0; k--) begin
         lim = SLOT_COUNT << k;
         if (lim < tlca_pkg::ID_SPAN && int'(r) >= lim) begin
            r = r - tlca_pkg::ID_W'(lim);
         end
      end
      return SLOT_W'(r);
   endfunction

   function automatic logic [ANC_AW-1:0] anc_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [LVL_W-1:0] l);
      return ANC_AW'(s) * ANC_AW'(LIFT_LEVELS) + ANC_AW'(l);
   endfunction

   tlca_pkg::depth_type depth_mem [SLOT_COUNT];
   tlca_pkg::node_type  anc_mem   [ANC_DEPTH];

   tlca_pkg::depth_type dep_a_ff, dep_b_ff;
   logic                dep_za_ff, dep_zb_ff;
   tlca_pkg::node_type  anc_a_ff, anc_b_ff;
   logic                anc_za_ff, anc_zb_ff;

   tlca_pkg::node_type  x_ff, x_in;
   tlca_pkg::node_type  y_ff, y_in;
   tlca_pkg::node_type  cand_ff, cand_in;
   tlca_pkg::depth_type dy_ff, dy_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic                pick_ff, pick_in;

   tlca_pkg::depth_type dep_a_val, dep_b_val;
   tlca_pkg::node_type  anc_a_val, anc_b_val, pick_val;
   logic [LVL_W-1:0]    lvl_dn;
   logic [SLOT_W-1:0]   slot_a, dep_ra_slot, dep_rb_slot, anc_ra_slot, anc_rb_slot;
   tlca_pkg::node_type  dep_ra_node, anc_ra_node, anc_rb_node;
   logic [LVL_W-1:0]    anc_ra_lvl, anc_rb_lvl;
   logic [ANC_AW-1:0]   anc_ra, anc_rb, anc_wa;
   logic                dep_we, anc_we;
   tlca_pkg::depth_type dep_wd;
   tlca_pkg::node_type  anc_wd;
   logic                swap, take;

   // Slot zero is the sentinel: its depth and ancestors always read as zero.
   assign dep_a_val = dep_za_ff ? '0 : dep_a_ff;
   assign dep_b_val = dep_zb_ff ? '0 : dep_b_ff;
   assign anc_a_val = anc_za_ff ? '0 : anc_a_ff;
   assign anc_b_val = anc_zb_ff ? '0 : anc_b_ff;
   assign pick_val  = pick_ff ? anc_b_val : anc_a_val;
   assign lvl_dn    = (lvl_ff == '0) ? '0 : lvl_ff - LVL_W'(1);
   assign slot_a    = slot_of(req_a);
   assign swap      = (dep_a_val < dep_b_val);
   assign take      = (dep_a_val >= dy_ff);

   always_comb begin
      case (ctl.op)
         tlca_pkg::OP_DEP_RD_PARENT: dep_ra_node = req_b;
         tlca_pkg::OP_L1_PICK:       dep_ra_node = pick_val;
         default:                    dep_ra_node = req_a;
      endcase
      dep_ra_slot = slot_of(dep_ra_node);
      dep_rb_slot = slot_of(req_b);

      anc_ra_node = (ctl.op == tlca_pkg::OP_ANC_RD_MID) ? cand_ff : x_ff;
      anc_ra_lvl  = (ctl.op == tlca_pkg::OP_ANC_RD_MID || ctl.op == tlca_pkg::OP_L1_STEP)
                    ? lvl_dn : lvl_ff;
      anc_rb_node = (ctl.op == tlca_pkg::OP_L1_STEP) ? cand_ff : y_ff;
      anc_rb_lvl  = (ctl.op == tlca_pkg::OP_L1_STEP) ? lvl_dn : lvl_ff;
      anc_ra_slot = slot_of(anc_ra_node);
      anc_rb_slot = slot_of(anc_rb_node);
      anc_ra      = anc_addr(anc_ra_slot, anc_ra_lvl);
      anc_rb      = anc_addr(anc_rb_slot, anc_rb_lvl);

      dep_we  = (ctl.op == tlca_pkg::OP_INS_HEAD);
      dep_wd  = dep_a_val + tlca_pkg::DEPTH_W'(1);
      anc_we  = (ctl.op == tlca_pkg::OP_INS_HEAD) || (ctl.op == tlca_pkg::OP_INS_FILL);
      anc_wa  = anc_addr(slot_a, (ctl.op == tlca_pkg::OP_INS_HEAD) ? '0 : lvl_ff);
      anc_wd  = (ctl.op == tlca_pkg::OP_INS_HEAD) ? req_b : anc_a_val;

      x_in    = x_ff;
      y_in    = y_ff;
      cand_in = cand_ff;
      dy_in   = dy_ff;
      lvl_in  = lvl_ff;
      pick_in = pick_ff;
      case (ctl.op)
         tlca_pkg::OP_INS_HEAD: begin
            cand_in = req_b;
            lvl_in  = LVL_W'(1);
         end
         tlca_pkg::OP_INS_FILL: begin
            // The last level of the row ends the insert; the level returns to zero.
            cand_in = anc_a_val;
            lvl_in  = (lvl_ff == LVL_TOP) ? '0 : lvl_ff + LVL_W'(1);
         end
         tlca_pkg::OP_Q_ORDER: begin
            // The deeper node becomes x; y keeps the shallower depth.
            x_in   = swap ? req_b : req_a;
            y_in   = swap ? req_a : req_b;
            dy_in  = swap ? dep_a_val : dep_b_val;
            lvl_in = LVL_TOP;
         end
         tlca_pkg::OP_ANC_RD_X: begin
            pick_in = 1'b0;
         end
         tlca_pkg::OP_L1_PICK: begin
            cand_in = pick_val;
         end
         tlca_pkg::OP_L1_STEP: begin
            // Both possible next rows are fetched now; pick selects next step.
            if (take) begin
               x_in = cand_ff;
            end
            pick_in = take;
            lvl_in  = lvl_dn;
         end
         tlca_pkg::OP_LVL_TOP: begin
            lvl_in = LVL_TOP;
         end
         tlca_pkg::OP_L2_STEP: begin
            if (anc_a_val != anc_b_val) begin
               x_in = anc_a_val;
               y_in = anc_b_val;
            end
            lvl_in = lvl_dn;
         end
         default: begin
         end
      endcase
   end

   assign status.slot0    = (slot_a == '0);
   assign status.lvl_more = (lvl_ff != LVL_TOP);
   assign status.lvl_nz   = (lvl_ff != '0);
   assign status.xy_eq    = (x_ff == y_ff);

   assign result.valid = (ctl.op == tlca_pkg::OP_OUT_ANC) || (ctl.op == tlca_pkg::OP_OUT_X);
   assign result.node  = (ctl.op == tlca_pkg::OP_OUT_X) ? x_ff : anc_a_val;

   always_ff @(posedge clock) begin
      if (dep_we) begin
         depth_mem[slot_a] <= dep_wd;
      end
      if (anc_we) begin
         anc_mem[anc_wa] <= anc_wd;
      end
      dep_a_ff  <= depth_mem[dep_ra_slot];
      dep_b_ff  <= depth_mem[dep_rb_slot];
      dep_za_ff <= (dep_ra_slot == '0);
      dep_zb_ff <= (dep_rb_slot == '0);
      anc_a_ff  <= anc_mem[anc_ra];
      anc_b_ff  <= anc_mem[anc_rb];
      anc_za_ff <= (anc_ra_slot == '0);
      anc_zb_ff <= (anc_rb_slot == '0);
      x_ff      <= x_in;
      y_ff      <= y_in;
      cand_ff   <= cand_in;
      dy_ff     <= dy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff  <= '0;
         pick_ff <= 1'b0;
      end else begin
         lvl_ff  <= lvl_in;
         pick_ff <= pick_in;
      end
   end

   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LVL_TOP)
      else $error("lifting level outside the table row");

endmodule

// ===== dv/tree_lca_binary_lifting_core_tb.sv =====
// ---------------------------------------------------------------------------
// tree_lca_binary_lifting_core_tb: self-checking bench for the LCA engine
// Builds trees through insert words, asks lowest common ancestor queries and
// compares every result word with a software copy of the lifting tables.
// ---------------------------------------------------------------------------

typedef bit [tlca_pkg::ID_W-1:0]    id_bits;
typedef bit [tlca_pkg::DEPTH_W-1:0] depth_bits;

localparam bit REQ_INSERT = 1'b0;
localparam bit REQ_QUERY  = 1'b1;

// Software copy of the depth store and ancestor table, with the answers
// that the engine still owes.
class lca_tracker #(int LEVELS = 10);
   depth_bits depth_tbl [tlca_pkg::ID_SPAN];
   id_bits    hop_tbl   [tlca_pkg::ID_SPAN][LEVELS];
   id_bits    lca_due   [$];
   int        errors;

   // Node 0 is never written, so its all-zero row stands for the sentinel.
   function void graft(id_bits node, id_bits parent);
      if (node == 0) return;
      depth_tbl[node]  = depth_tbl[parent] + 1'b1;
      hop_tbl[node][0] = parent;
      for (int l = 1; l < LEVELS; l++)
         hop_tbl[node][l] = hop_tbl[hop_tbl[node][l-1]][l-1];
   endfunction

   function id_bits meet(id_bits x, id_bits y);
      id_bits t;
      if (depth_tbl[x] < depth_tbl[y]) begin
         t = x;
         x = y;
         y = t;
      end
      for (int l = LEVELS - 1; l >= 0; l--)
         if (depth_tbl[hop_tbl[x][l]] >= depth_tbl[y]) x = hop_tbl[x][l];
      if (x == y) return x;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (hop_tbl[x][l] != hop_tbl[y][l]) begin
            x = hop_tbl[x][l];
            y = hop_tbl[y][l];
         end
      end
      return hop_tbl[x][0];
   endfunction

   function void record_request(bit kind, id_bits a, id_bits b);
      if (kind == REQ_QUERY) lca_due = {lca_due, meet(a, b)};
      else graft(a, b);
   endfunction

   function void check_ancestor(logic [tlca_pkg::ID_W-1:0] got);
      id_bits want;
      if (lca_due.size() == 0) begin
         errors++;
         $error("rsp_ancestor_node: expected none, actual %0d", got);
         return;
      end
      want = lca_due.pop_front();
      if (got !== want) begin
         errors++;
         $error("rsp_ancestor_node: expected %0d, actual %0d", want, got);
      end
   endfunction
endclass

module tree_lca_binary_lifting_core_tb;

   localparam int LEVELS         = 10;
   localparam int LAST_ID        = tlca_pkg::ID_SPAN - 1;
   // Settle time: the longest query, which runs both lifting loops, plus a margin.
   localparam int SETTLE_CYCLES  = 4*LEVELS + 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MIX_ITEMS      = 100;
   localparam int QUIET_TAIL     = 40;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      start      = 1'b0;
   logic                      busy;
   logic                      req_type   = 1'b0;
   logic [tlca_pkg::ID_W-1:0] req_node_a = '0;
   logic [tlca_pkg::ID_W-1:0] req_node_b = '0;
   logic                      rsp_strobe;
   logic [tlca_pkg::ID_W-1:0] rsp_ancestor_node;

   lca_tracker #(LEVELS) tracker;

   // Every node that has been inserted at least once. Queries and parents
   // are drawn from here so that no table entry is read before it is written.
   bit     known [tlca_pkg::ID_SPAN];
   id_bits known_ids [$];
   id_bits order [LAST_ID];
   int     gap_pct;
   int     stall_count = 0;

   tree_lca_binary_lifting_core #(
      .NODE_COUNT(tlca_pkg::ID_SPAN),
      .LIFT_LEVELS(LEVELS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_node_a(req_node_a),
      .req_node_b(req_node_b),
      .rsp_strobe(rsp_strobe),
      .rsp_ancestor_node(rsp_ancestor_node)
   );

   initial forever #5 clock = ~clock;

   // Result words cannot be held off, so each one is checked at the edge
   // that ends its strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) tracker.check_ancestor(rsp_ancestor_node);
   end

   // The run is abandoned if neither a request word nor a result word moves
   // for far longer than the slowest query plus the longest sender pause.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         stall_count <= 0;
      end else if (stall_count == WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // Offers one request word and returns once it has been taken. Start is
   // left high so that back-to-back words need no extra edge; before the
   // word, the sender may pause, sometimes counting the pause from the
   // moment busy falls so that gaps also land just after completion.
   task automatic send_word(input bit kind, input id_bits a, input id_bits b);
      if ($urandom_range(0, 99) < gap_pct) begin
         @(negedge clock);
         start <= 1'b0;
         if ($urandom_range(0, 1)) begin
            do @(posedge clock); while (busy);
         end
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
      @(negedge clock);
      start      <= 1'b1;
      req_type   <= kind;
      req_node_a <= a;
      req_node_b <= b;
      do @(posedge clock); while (busy);
      tracker.record_request(kind, a, b);
      if (kind == REQ_INSERT && a != 0 && !known[a]) begin
         known[a] = 1'b1;
         known_ids = {known_ids, a};
      end
   endtask

   // Stops offering words until every owed answer has arrived, then lets the
   // engine run out any insert still in progress.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (tracker.lca_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic shuffle_ids();
      id_bits t;
      int     j;
      for (int i = 0; i < LAST_ID; i++) order[i] = id_bits'(i + 1);
      for (int i = LAST_ID - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
   endtask

   function automatic id_bits any_known();
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
   endfunction

   initial begin
      id_bits x;
      id_bits y;
      id_bits tail;
      int     r;
      int     next_new;
      id_bits rebuilt [$];

      tracker = new();
      gap_pct = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. A small tree with two roots: 1 above 2 and 3, a
      // branch 2-4-5-1023-1022 and 512 under 3, with 700 standing alone.
      send_word(REQ_INSERT, 1, 0);
      send_word(REQ_INSERT, 2, 1);
      send_word(REQ_INSERT, 3, 1);
      send_word(REQ_INSERT, 4, 2);
      send_word(REQ_INSERT, 5, 4);
      send_word(REQ_INSERT, id_bits'(LAST_ID), 5);
      send_word(REQ_INSERT, 512, 3);
      send_word(REQ_INSERT, 700, 0);
      send_word(REQ_INSERT, id_bits'(LAST_ID - 1), id_bits'(LAST_ID));
      // An insert of the sentinel must leave its row untouched.
      send_word(REQ_INSERT, 0, 1);
      send_word(REQ_QUERY, 4, 5);
      send_word(REQ_QUERY, id_bits'(LAST_ID - 1), 512);
      send_word(REQ_QUERY, id_bits'(LAST_ID), id_bits'(LAST_ID));
      // Separate roots have no common ancestor, and the sentinel answers 0.
      send_word(REQ_QUERY, id_bits'(LAST_ID), 700);
      send_word(REQ_QUERY, 0, 5);
      send_word(REQ_QUERY, 5, 0);
      send_word(REQ_QUERY, 0, 0);
      send_word(REQ_QUERY, 1, id_bits'(LAST_ID - 1));
      // Moving 4 under 3 rewrites its row but leaves the rows of 5 and
      // below as they were.
      send_word(REQ_INSERT, 4, 3);
      send_word(REQ_QUERY, 5, 512);
      send_word(REQ_QUERY, 4, 512);
      send_word(REQ_QUERY, id_bits'(LAST_ID), 4);
      drain();

      // A single chain through every id in random order reaches depth 1023
      // and uses every lifting level. Hanging the head under the tail then
      // wraps its depth round to zero.
      shuffle_ids();
      tail = 0;
      for (int i = 0; i < LAST_ID; i++) begin
         if (i % 64 == 0) gap_pct = 25 * $urandom_range(0, 2);
         send_word(REQ_INSERT, order[i], tail);
         tail = order[i];
         if ($urandom_range(0, 31) == 0) send_word(REQ_QUERY, any_known(), any_known());
      end
      send_word(REQ_INSERT, order[0], tail);
      send_word(REQ_INSERT, order[1], order[0]);
      send_word(REQ_QUERY, order[0], tail);
      send_word(REQ_QUERY, order[1], order[LAST_ID/2]);
      send_word(REQ_QUERY, tail, order[2]);
      send_word(REQ_QUERY, order[1], order[0]);
      drain();

      // Mixed part. Nodes are hung again in a fresh order, each as a root or
      // under a node already rebuilt here, favouring the newest one to grow
      // depth, so a branching forest takes shape; queries run on it throughout.
      // A few words are noise: sentinel inserts and re-inserts of rebuilt nodes.
      shuffle_ids();
      next_new = 0;
      for (int i = 0; i < MIX_ITEMS; i++) begin
         if (i % 64 == 0) gap_pct = 25 * $urandom_range(0, 2);
         if (i >= MIX_ITEMS - QUIET_TAIL) gap_pct = 0;
         r = $urandom_range(0, 99);
         if (rebuilt.size() == 0 || (r < 40 && next_new < LAST_ID)) begin
            x = order[next_new];
            next_new++;
            r = $urandom_range(0, 99);
            if (rebuilt.size() == 0 || r < 8) y = 0;
            else if (r < 55) y = rebuilt[rebuilt.size() - 1];
            else y = rebuilt[$urandom_range(0, rebuilt.size() - 1)];
            send_word(REQ_INSERT, x, y);
            rebuilt = {rebuilt, x};
         end else if (r < 45) begin
            x = $urandom_range(0, 1) ? id_bits'(0)
                                     : rebuilt[$urandom_range(0, rebuilt.size() - 1)];
            send_word(REQ_INSERT, x, rebuilt[$urandom_range(0, rebuilt.size() - 1)]);
         end else begin
            x = rebuilt[$urandom_range(0, rebuilt.size() - 1)];
            r = $urandom_range(0, 99);
            if (r < 60) begin
               y = rebuilt[$urandom_range(0, rebuilt.size() - 1)];
            end else if (r < 80) begin
               // Pair a node with one of its own ancestors.
               y = x;
               repeat ($urandom_range(0, 24)) y = tracker.hop_tbl[y][0];
            end else if (r < 87) begin
               y = x;
            end else if (r < 93) begin
               y = 0;
            end else begin
               y = any_known();
            end
            if ($urandom_range(0, 1)) send_word(REQ_QUERY, x, y);
            else send_word(REQ_QUERY, y, x);
         end
      end
      drain();

      if (tracker.errors == 0 && tracker.lca_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tlca_pkg.sv
hdl/tlca_useq.sv
hdl/tlca_dpath.sv
hdl/tree_lca_binary_lifting_core.sv
dv/tree_lca_binary_lifting_core_tb.sv
